### design/ntm_pkg.sv
`timescale 1ns / 1ps

package ntm_pkg;

	// item field widths
	localparam int SAMPLE_W = 12;
	localparam int SUM_W = 16;
	localparam int TEMP_W = 7;
	localparam int CHAN_W = 2;
	localparam int NUM_CHAN = 3;

	// calibration table
	localparam int ROM_SIZE = 126;
	localparam int ROM_IDX_W = 7;

	// register port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [TEMP_W-1:0] temp_t;
	typedef logic [CHAN_W-1:0] chan_t;

	typedef enum logic [2:0] {
		REG_LIMIT_ONE   = 3'd0,
		REG_LIMIT_TWO   = 3'd1,
		REG_LIMIT_THREE = 3'd2,
		REG_DRIVE_EN    = 3'd3,
		REG_SYNC_HOLD   = 3'd4,
		REG_OUT_ALLOWED = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_CHAN-1:0][TEMP_W-1:0] limit;
		logic                            drive_enable;
		logic                            sync_hold;
		logic                            outputs_allowed;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take_sample;
		logic div_step;
		logic srch_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_sample;
		logic srch_last;
		logic out_free;
	} status_t;

	// thermistor converter codes, rising, one per degree
	localparam logic [SAMPLE_W-1:0] NTC_ROM [ROM_SIZE] = '{
		12'd981,  12'd1018, 12'd1056, 12'd1094, 12'd1133, 12'd1173, 12'd1214, 12'd1255,
		12'd1296, 12'd1338, 12'd1381, 12'd1424, 12'd1467, 12'd1511, 12'd1555, 12'd1599,
		12'd1644, 12'd1689, 12'd1734, 12'd1779, 12'd1824, 12'd1869, 12'd1914, 12'd1959,
		12'd2004, 12'd2048, 12'd2093, 12'd2137, 12'd2181, 12'd2225, 12'd2268, 12'd2311,
		12'd2353, 12'd2395, 12'd2436, 12'd2477, 12'd2518, 12'd2557, 12'd2596, 12'd2635,
		12'd2673, 12'd2710, 12'd2747, 12'd2782, 12'd2818, 12'd2852, 12'd2886, 12'd2919,
		12'd2951, 12'd2983, 12'd3014, 12'd3044, 12'd3074, 12'd3102, 12'd3130, 12'd3158,
		12'd3184, 12'd3210, 12'd3236, 12'd3260, 12'd3284, 12'd3308, 12'd3330, 12'd3353,
		12'd3374, 12'd3395, 12'd3415, 12'd3435, 12'd3454, 12'd3472, 12'd3490, 12'd3508,
		12'd3525, 12'd3541, 12'd3557, 12'd3573, 12'd3588, 12'd3602, 12'd3616, 12'd3630,
		12'd3643, 12'd3656, 12'd3669, 12'd3681, 12'd3693, 12'd3704, 12'd3715, 12'd3725,
		12'd3735, 12'd3745, 12'd3755, 12'd3764, 12'd3773, 12'd3782, 12'd3791, 12'd3799,
		12'd3807, 12'd3815, 12'd3823, 12'd3830, 12'd3837, 12'd3844, 12'd3851, 12'd3857,
		12'd3863, 12'd3869, 12'd3875, 12'd3881, 12'd3887, 12'd3893, 12'd3898, 12'd3903,
		12'd3908, 12'd3913, 12'd3918, 12'd3923, 12'd3928, 12'd3932, 12'd3936, 12'd3941,
		12'd3945, 12'd3949, 12'd3953, 12'd3956, 12'd3960, 12'd3964
	};

endpackage

### design/ntm_in_if.sv
`timescale 1ns / 1ps

interface ntm_in_if;
	logic             valid;
	logic             ready;
	ntm_pkg::sample_t adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

### design/ntm_out_if.sv
`timescale 1ns / 1ps

interface ntm_out_if;
	logic             valid;
	logic             ready;
	ntm_pkg::chan_t   channel;
	ntm_pkg::sample_t average;
	ntm_pkg::temp_t   temperature;
	logic             relay_one;
	logic             relay_two;
	logic             relay_three;

	modport source (
		output valid, output channel, output average, output temperature,
		output relay_one, output relay_two, output relay_three,
		input ready
	);
	modport sink (
		input valid, input channel, input average, input temperature,
		input relay_one, input relay_two, input relay_three,
		output ready
	);
endinterface

### design/ntm_regs.sv
`timescale 1ns / 1ps

module ntm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ntm_pkg::ADDR_W-1:0]  paddr,
	input  logic [ntm_pkg::DATA_W-1:0]  pwdata,
	output logic [ntm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output ntm_pkg::cfg_t               cfg
);

	ntm_pkg::cfg_t     cfg_q;
	ntm_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = ntm_pkg::reg_idx_t'(paddr[ntm_pkg::ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				ntm_pkg::REG_LIMIT_ONE: begin
					cfg_q.limit[0] <= pwdata[ntm_pkg::TEMP_W-1:0];
				end
				ntm_pkg::REG_LIMIT_TWO: begin
					cfg_q.limit[1] <= pwdata[ntm_pkg::TEMP_W-1:0];
				end
				ntm_pkg::REG_LIMIT_THREE: begin
					cfg_q.limit[2] <= pwdata[ntm_pkg::TEMP_W-1:0];
				end
				ntm_pkg::REG_DRIVE_EN: begin
					cfg_q.drive_enable <= pwdata[0];
				end
				ntm_pkg::REG_SYNC_HOLD: begin
					cfg_q.sync_hold <= pwdata[0];
				end
				ntm_pkg::REG_OUT_ALLOWED: begin
					cfg_q.outputs_allowed <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			ntm_pkg::REG_LIMIT_ONE:   prdata = ntm_pkg::DATA_W'(cfg_q.limit[0]);
			ntm_pkg::REG_LIMIT_TWO:   prdata = ntm_pkg::DATA_W'(cfg_q.limit[1]);
			ntm_pkg::REG_LIMIT_THREE: prdata = ntm_pkg::DATA_W'(cfg_q.limit[2]);
			ntm_pkg::REG_DRIVE_EN:    prdata = ntm_pkg::DATA_W'(cfg_q.drive_enable);
			ntm_pkg::REG_SYNC_HOLD:   prdata = ntm_pkg::DATA_W'(cfg_q.sync_hold);
			ntm_pkg::REG_OUT_ALLOWED: prdata = ntm_pkg::DATA_W'(cfg_q.outputs_allowed);
			default:                  prdata = '0;
		endcase
	end

endmodule

### design/ntm_ctrl.sv
`timescale 1ns / 1ps

module ntm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ntm_pkg::status_t status,
	output ntm_pkg::cmd_t    cmd
);

	ntm_pkg::state_t state_q;
	ntm_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntm_pkg::ST_ACCUM;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ntm_pkg::ST_ACCUM: begin
				if (in_valid && status.last_sample) state_nxt = ntm_pkg::ST_DIVIDE;
			end
			ntm_pkg::ST_DIVIDE: begin
				state_nxt = ntm_pkg::ST_SEARCH;
			end
			ntm_pkg::ST_SEARCH: begin
				if (status.srch_last) state_nxt = ntm_pkg::ST_EMIT;
			end
			ntm_pkg::ST_EMIT: begin
				if (status.out_free) state_nxt = ntm_pkg::ST_ACCUM;
			end
			default: begin
				state_nxt = ntm_pkg::ST_ACCUM;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ntm_pkg::ST_ACCUM: begin
				in_ready        = 1'b1;
				cmd.take_sample = in_valid;
			end
			ntm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ntm_pkg::ST_SEARCH: begin
				cmd.srch_step = 1'b1;
			end
			ntm_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

### design/ntm_dp.sv
`timescale 1ns / 1ps

module ntm_dp #(
	parameter int TABLE_ENTRIES    = 126,
	parameter int SAMPLES_PER_READ = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ntm_pkg::cmd_t    cmd,
	output ntm_pkg::status_t status,
	input  ntm_pkg::cfg_t    cfg,
	input  ntm_pkg::sample_t adc_sample,
	output logic             out_valid,
	input  logic             out_ready,
	output ntm_pkg::chan_t   channel,
	output ntm_pkg::sample_t average,
	output ntm_pkg::temp_t   temperature,
	output logic             relay_one,
	output logic             relay_two,
	output logic             relay_three
);

	localparam int CNT_W = $clog2(SAMPLES_PER_READ + 1);
	localparam int N_EFF = (TABLE_ENTRIES > ntm_pkg::ROM_SIZE) ? ntm_pkg::ROM_SIZE
	                                                            : TABLE_ENTRIES;
	localparam int IW    = ntm_pkg::ROM_IDX_W;
	localparam int SW    = ntm_pkg::SUM_W;
	localparam int NC    = ntm_pkg::NUM_CHAN;
	localparam int TW    = ntm_pkg::TEMP_W;
	localparam int PW    = 2 * SW + 1;

	// reciprocal of the sample count, rounded up, exact for any 16-bit sum
	localparam int            DIV_SH = SW + $clog2(SAMPLES_PER_READ);
	localparam logic [SW:0]   RECIP  = (SW + 1)'(((64'd1 << DIV_SH) +
	                                   64'(SAMPLES_PER_READ) - 64'd1) /
	                                   64'(SAMPLES_PER_READ));

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READ - 1);
	localparam logic [IW-1:0]    IDX_LAST = IW'(N_EFF - 2);

	// accumulator
	logic [SW-1:0]    sum_q;
	logic [CNT_W-1:0] count_q;
	logic [SW-1:0]    sum_nxt;

	// divider: num_q holds the finished sum, avg_q the quotient
	logic [SW-1:0]    num_q;
	logic [PW-1:0]    prod;
	ntm_pkg::sample_t avg_q;

	// table scan
	logic [IW-1:0]    idx_q;
	ntm_pkg::temp_t   found_q;
	ntm_pkg::sample_t rom_lo;
	ntm_pkg::sample_t rom_hi;

	// channel state and result register
	ntm_pkg::chan_t           chan_q;
	logic [NC-1:0][TW-1:0]    temps_q;
	logic [NC-1:0]            relay_q;
	logic [NC-1:0][TW-1:0]    temps_nxt;
	logic [NC-1:0]            relay_nxt;
	logic                     out_valid_q;
	ntm_pkg::chan_t           chan_o_q;
	ntm_pkg::sample_t         avg_o_q;
	ntm_pkg::temp_t           temp_o_q;
	logic [NC-1:0]            relay_o_q;

	assign sum_nxt = sum_q + SW'(adc_sample);

	// sample accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.take_sample) begin
			if (count_q == CNT_LAST) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_nxt;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// divide by the sample count as a multiply by its reciprocal, registered in the divide state
	assign prod = PW'(num_q) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.take_sample && count_q == CNT_LAST) begin
			num_q <= sum_nxt;
		end
		if (cmd.div_step) begin
			avg_q <= prod[DIV_SH +: ntm_pkg::SAMPLE_W];
		end
	end

	// table scan, one bracket per cycle
	assign rom_lo = ntm_pkg::NTC_ROM[idx_q];
	assign rom_hi = ntm_pkg::NTC_ROM[idx_q + IW'(1)];

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			idx_q   <= '0;
			found_q <= '0;
		end else if (cmd.srch_step) begin
			if (avg_q >= rom_lo && avg_q < rom_hi) found_q <= TW'(idx_q);
			idx_q <= idx_q + IW'(1);
		end
	end

	// relay rule on the updated temperatures
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			temps_nxt[k] = (chan_q == ntm_pkg::CHAN_W'(k)) ? found_q : temps_q[k];
			if (cfg.outputs_allowed) begin
				relay_nxt[k] = ~((temps_nxt[k] < cfg.limit[k]) & cfg.drive_enable &
				                 ~cfg.sync_hold);
			end else begin
				relay_nxt[k] = relay_q[k];
			end
		end
	end

	// channel state update and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			temps_q     <= '0;
			relay_q     <= '1;
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			chan_q      <= (chan_q == ntm_pkg::CHAN_W'(NC - 1)) ? '0
			                                                    : chan_q + ntm_pkg::CHAN_W'(1);
			temps_q     <= temps_nxt;
			relay_q     <= relay_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			chan_o_q  <= chan_q;
			avg_o_q   <= avg_q;
			temp_o_q  <= found_q;
			relay_o_q <= relay_nxt;
		end
	end

	assign status.last_sample = (count_q == CNT_LAST);
	assign status.srch_last   = (idx_q == IDX_LAST);
	assign status.out_free    = ~out_valid_q | out_ready;

	assign out_valid   = out_valid_q;
	assign channel     = chan_o_q;
	assign average     = avg_o_q;
	assign temperature = temp_o_q;
	assign relay_one   = relay_o_q[0];
	assign relay_two   = relay_o_q[1];
	assign relay_three = relay_o_q[2];

endmodule

### design/ntc_temperature_monitor_unit.sv
`timescale 1ns / 1ps
// after the last sample of a channel is taken, the average is divided out, the table
//   is scanned and the result item is registered in the emit state
// intake: samples are taken one per cycle, then input stalls for the divide step
//   (reciprocal multiply), the table scan (one entry per cycle) and the emit state,
//   and stays stalled longer if results stall
// reset: arst_n clears sums, counters, channel and temperatures, the relay state goes inactive (1)

module ntc_temperature_monitor_unit #(
	parameter int TABLE_ENTRIES    = 126,
	parameter int SAMPLES_PER_READ = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ntm_in_if.sink                     adc_in,
	ntm_out_if.source                  res_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ntm_pkg::ADDR_W-1:0] paddr,
	input  logic [ntm_pkg::DATA_W-1:0] pwdata,
	output logic [ntm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	ntm_pkg::cfg_t    cfg;
	ntm_pkg::cmd_t    cmd;
	ntm_pkg::status_t status;

	ntm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ntm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (adc_in.valid),
		.in_ready (adc_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ntm_dp #(
		.TABLE_ENTRIES    (TABLE_ENTRIES),
		.SAMPLES_PER_READ (SAMPLES_PER_READ)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg         (cfg),
		.adc_sample  (adc_in.adc_sample),
		.out_valid   (res_out.valid),
		.out_ready   (res_out.ready),
		.channel     (res_out.channel),
		.average     (res_out.average),
		.temperature (res_out.temperature),
		.relay_one   (res_out.relay_one),
		.relay_two   (res_out.relay_two),
		.relay_three (res_out.relay_three)
	);

endmodule

### design/ntm_checker.sv
`timescale 1ns / 1ps

module ntm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input ntm_pkg::chan_t               channel,
	input ntm_pkg::sample_t             average,
	input ntm_pkg::temp_t               temperature,
	input logic                         relay_one,
	input logic                         relay_two,
	input logic                         relay_three
);

	// stalled result item stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// stalled result item keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(channel) && $stable(average) &&
		$stable(temperature) && $stable(relay_one) && $stable(relay_two) &&
		$stable(relay_three))
		else $error("result payload changed while stalled");

	// a new result item is only launched while sample intake is held off
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result item appeared while samples were being taken");

	// only three channels exist
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel != 2'd3)
		else $error("result item names a channel that does not exist");

	// temperature stays inside the table range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature < 7'd125)
		else $error("result temperature beyond the calibration table");

endmodule

bind ntc_temperature_monitor_unit ntm_checker u_ntm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (adc_in.ready),
	.out_valid   (res_out.valid),
	.out_ready   (res_out.ready),
	.channel     (res_out.channel),
	.average     (res_out.average),
	.temperature (res_out.temperature),
	.relay_one   (res_out.relay_one),
	.relay_two   (res_out.relay_two),
	.relay_three (res_out.relay_three)
);
